// ===== hdl/ocpf_pkg.sv =====
// shared types and codes for the output channel pulse/follow block
package ocpf_pkg;

  localparam int unsigned DutyRegW = 9;
  localparam int unsigned PulseW   = 16;
  localparam int unsigned LevelW   = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SET     = 2'd1,
    OP_MACHINE = 2'd2,
    OP_UNUSED  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    MODE_MANUAL    = 2'd0,
    MODE_SEQUENCER = 2'd1,
    MODE_FOLLOW    = 2'd2,
    MODE_MACHINE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_DIGITAL = 2'd0,
    KIND_LED     = 2'd1,
    KIND_PWM     = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    LS_OFF     = 2'd0,
    LS_ON      = 2'd1,
    LS_PULSING = 2'd2,
    LS_INVALID = 2'd3
  } lstate_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_REFUSED = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CHANNEL_MODE = 3'd0,
    REG_OUTPUT_KIND  = 3'd1,
    REG_PULSE_WIDTH  = 3'd2,
    REG_DUTY_LEVEL   = 3'd3,
    REG_ACTIVE_LEVEL = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]        channel_mode;
    logic [1:0]        output_kind;
    logic [PulseW-1:0] pulse_width;
    logic [LevelW-1:0] duty_level;
    logic              active_level;
  } cfg_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [1:0] request_value;
    logic       follow_level;
  } item_t;

  typedef struct packed {
    logic [1:0]          logical_now;
    logic                pin_drive;
    logic [DutyRegW-1:0] led_duty;
    logic [1:0]          status_code;
  } result_t;

endpackage

// ===== hdl/ocpf_cfg_regs.sv =====
// configuration register file of the output channel
module ocpf_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [ocpf_pkg::CfgIdxW-1:0]  wr_idx_i,
  input  logic [ocpf_pkg::CfgDataW-1:0] wr_data_i,
  output ocpf_pkg::cfg_t                cfg_o
);
  import ocpf_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_mode <= '0;
      cfg_q.output_kind  <= '0;
      cfg_q.pulse_width  <= '0;
      cfg_q.duty_level   <= '0;
      cfg_q.active_level <= 1'b1;
    end else if (wr_en_i) begin
      case (wr_idx_i)
        REG_CHANNEL_MODE: cfg_q.channel_mode <= wr_data_i[1:0];
        REG_OUTPUT_KIND:  cfg_q.output_kind  <= wr_data_i[1:0];
        REG_PULSE_WIDTH:  cfg_q.pulse_width  <= wr_data_i[PulseW-1:0];
        REG_DUTY_LEVEL:   cfg_q.duty_level   <= wr_data_i[LevelW-1:0];
        REG_ACTIVE_LEVEL: cfg_q.active_level <= wr_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/ocpf_core.sv =====
// channel state, pulse timer and drive mapping, one item per step
module ocpf_core #(
  parameter int unsigned DUTY_BITS  = 8,
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  ocpf_pkg::cfg_t    cfg_i,
  input  ocpf_pkg::item_t   item_i,
  output ocpf_pkg::result_t result_o
);
  import ocpf_pkg::*;

  // full-scale duty as kept in the 9-bit duty register
  localparam logic [DutyRegW-1:0] FullDuty =
    (DUTY_BITS < DutyRegW) ? DutyRegW'(1 << DUTY_BITS) : '0;

  logic [1:0]            logical_q, logical_d;
  logic [TIMER_BITS-1:0] ticks_q, ticks_d;
  logic                  drive_q, drive_d;
  logic [DutyRegW-1:0]   duty_q, duty_d;

  logic            sw_en, do_pulse, do_adv;
  logic [1:0]      sw_val;
  logic [1:0]      status;
  logic            match;
  logic            user_mode;
  logic [TIMER_BITS-1:0] pw_ticks;

  assign user_mode = (cfg_i.channel_mode == MODE_MANUAL) ||
                     (cfg_i.channel_mode == MODE_FOLLOW);
  assign pw_ticks  = TIMER_BITS'(cfg_i.pulse_width);

  // decode the item into switch / pulse start / pulse advance
  always_comb begin
    sw_en    = 1'b0;
    sw_val   = item_i.request_value;
    do_pulse = 1'b0;
    do_adv   = 1'b0;
    status   = ST_DONE;
    case (item_i.opcode)
      OP_TICK: begin
        if (cfg_i.channel_mode == MODE_MANUAL) begin
          do_adv = 1'b1;
        end else if (cfg_i.channel_mode == MODE_FOLLOW) begin
          if (cfg_i.pulse_width != '0) begin
            do_pulse = item_i.follow_level;
            do_adv   = !item_i.follow_level;
          end else begin
            sw_en  = 1'b1;
            sw_val = {1'b0, item_i.follow_level};
          end
        end
      end
      OP_SET: begin
        if (!user_mode) begin
          status = ST_REFUSED;
        end else if (item_i.request_value == LS_INVALID) begin
          status = ST_INVALID;
        end else if (item_i.request_value == LS_PULSING) begin
          do_pulse = 1'b1;
        end else begin
          sw_en = 1'b1;
        end
      end
      OP_MACHINE: begin
        if (cfg_i.channel_mode != MODE_MACHINE) begin
          status = ST_REFUSED;
        end else if (item_i.request_value == LS_INVALID) begin
          status = ST_INVALID;
        end else begin
          sw_en = 1'b1;
        end
      end
      default: ;
    endcase

    // running pulse: ends when the counter is at or reaches zero
    if (do_adv && logical_q == LS_PULSING) begin
      if (ticks_q <= TIMER_BITS'(1)) begin
        sw_en  = 1'b1;
        sw_val = LS_OFF;
      end
    end
    if (do_pulse) begin
      sw_en  = 1'b1;
      sw_val = LS_ON;
    end
  end

  assign match = (sw_val == {1'b0, cfg_i.active_level});

  always_comb begin
    logical_d = logical_q;
    ticks_d   = ticks_q;
    drive_d   = drive_q;
    duty_d    = duty_q;
    if (do_adv && logical_q == LS_PULSING && ticks_q != '0) begin
      ticks_d = ticks_q - TIMER_BITS'(1);
    end
    if (sw_en) begin
      logical_d = sw_val;
      if (cfg_i.output_kind == KIND_DIGITAL) begin
        drive_d = match;
      end else if (cfg_i.output_kind == KIND_LED) begin
        if (match) begin
          duty_d = cfg_i.active_level ? {1'b0, cfg_i.duty_level}
                                      : FullDuty - {1'b0, cfg_i.duty_level};
        end else begin
          duty_d = cfg_i.active_level ? '0 : FullDuty;
        end
      end
    end
    if (do_pulse) begin
      logical_d = LS_PULSING;
      ticks_d   = pw_ticks;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      logical_q <= LS_OFF;
      ticks_q   <= '0;
      drive_q   <= 1'b0;
      duty_q    <= '0;
    end else if (step_i) begin
      logical_q <= logical_d;
      ticks_q   <= ticks_d;
      drive_q   <= drive_d;
      duty_q    <= duty_d;
    end
  end

  assign result_o.logical_now = logical_d;
  assign result_o.pin_drive   = drive_d;
  assign result_o.led_duty    = duty_d;
  assign result_o.status_code = status;

endmodule

// ===== hdl/output_channel_pulse_follow.sv =====
// top level of the relay / led output channel with pulse and input follow
// a transaction passes through the input register and then the result register
// throughput: one transaction per cycle unless the result stream stalls; the state loop closes in the core
// a stalled result blocks input once the input register also holds a transaction
// reset (async, active low): channel off, timer and drive cleared, active_level = 1
// no clearing pass after reset; the block takes transactions on the first cycle
module output_channel_pulse_follow #(
  parameter int unsigned DUTY_BITS  = 8,
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // request_value[1:0], follow_level[2]
  input  logic [1:0]                    s_axis_tuser,  // opcode[1:0]
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // logical_now[1:0], pin_drive[2], led_duty[11:3], status_code[13:12]
  output logic [15:0]                   m_axis_tdata,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ocpf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ocpf_pkg::CfgDataW-1:0] cfg_data_i
);
  import ocpf_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    in_valid_q;
  result_t result_d, result_q;
  logic    out_valid_q;
  logic    step;     // item in the input register moves through the core
  logic    in_take;  // input transaction

  // config is always writable; the user must write it only while idle, the block itself does not enforce this
  assign cfg_ready_o = 1'b1;

  ocpf_cfg_regs u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (cfg_valid_i),
    .wr_idx_i (cfg_index_i),
    .wr_data_i(cfg_data_i),
    .cfg_o    (cfg)
  );

  // the result register frees up when empty or when it is taken this cycle
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.opcode        <= s_axis_tuser;
      item_q.request_value <= s_axis_tdata[1:0];
      item_q.follow_level  <= s_axis_tdata[2];
    end
  end

  ocpf_core #(
    .DUTY_BITS (DUTY_BITS),
    .TIMER_BITS(TIMER_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .cfg_i   (cfg),
    .item_i  (item_q),
    .result_o(result_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, result_q.status_code, result_q.led_duty,
                          result_q.pin_drive, result_q.logical_now};

endmodule
